/* rtl/bsub_pkg.sv */
// Shared types, constants and box helpers for the 3D box difference block.
// Used by bsub_front, bsub_queue, bsub_back and box_subtract_3d; no dependencies.
package bsub_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NUM_KINDS     = 7;
    localparam int KIND_W        = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [KIND_W-1:0]             t_kind;
    typedef logic [NUM_KINDS-1:0]          t_mask;

    // Piece kinds, emitted in ascending order. KIND_CLIP is the whole clipper.
    localparam t_kind KIND_FRONT  = 3'd0;
    localparam t_kind KIND_BEHIND = 3'd1;
    localparam t_kind KIND_RIGHT  = 3'd2;
    localparam t_kind KIND_LEFT   = 3'd3;
    localparam t_kind KIND_TOP    = 3'd4;
    localparam t_kind KIND_BOTTOM = 3'd5;
    localparam t_kind KIND_CLIP   = 3'd6;

    typedef struct packed {
        t_coord clipper_min_x;
        t_coord clipper_min_y;
        t_coord clipper_min_z;
        t_coord clipper_max_x;
        t_coord clipper_max_y;
        t_coord clipper_max_z;
        t_coord subject_min_x;
        t_coord subject_min_y;
        t_coord subject_min_z;
        t_coord subject_max_x;
        t_coord subject_max_y;
        t_coord subject_max_z;
    } t_req;

    typedef struct packed {
        t_coord piece_min_x;
        t_coord piece_min_y;
        t_coord piece_min_z;
        t_coord piece_max_x;
        t_coord piece_max_y;
        t_coord piece_max_z;
        logic   last_piece;
    } t_piece;

    typedef struct packed {
        t_coord lo_x;
        t_coord lo_y;
        t_coord lo_z;
        t_coord hi_x;
        t_coord hi_y;
        t_coord hi_z;
    } t_box;

    // One classified request waiting for the back end.
    typedef struct packed {
        t_box  clip;
        t_box  isect;
        t_mask mask;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic box_ok(t_box b);
        return (b.lo_x < b.hi_x) && (b.lo_y < b.hi_y) && (b.lo_z < b.hi_z);
    endfunction

    function automatic t_box build_piece(t_box c, t_box it, t_kind kind);
        t_box p;
        p = c;
        case (kind)
            KIND_FRONT: begin
                p.lo_x = it.hi_x; p.lo_y = it.lo_y; p.lo_z = it.lo_z;
            end
            KIND_BEHIND: begin
                p.hi_x = it.lo_x; p.hi_y = it.hi_y; p.hi_z = it.hi_z;
            end
            KIND_RIGHT: begin
                p.lo_x = it.lo_x; p.lo_y = it.lo_y; p.lo_z = it.hi_z;
            end
            KIND_LEFT: begin
                p.hi_x = it.hi_x; p.hi_y = it.lo_y; p.hi_z = it.hi_z;
            end
            KIND_TOP: begin
                p.lo_x = it.lo_x; p.lo_y = it.hi_y; p.lo_z = it.lo_z;
            end
            KIND_BOTTOM: begin
                p.hi_x = it.hi_x; p.hi_y = it.hi_y; p.hi_z = it.lo_z;
            end
            default: begin
                p = c;
            end
        endcase
        return p;
    endfunction

endpackage

/* rtl/box_subtract_3d.sv */
// Top level of the 3D box difference block: front end, queue, back end.
// Depends on bsub_pkg, bsub_front, bsub_queue and bsub_back.
//
// Usage:
//   Request channel: drive i_req and raise i_push; the request is taken at a
//   clock edge where i_push is high and o_full is low. One request can be
//   taken every cycle while the back end keeps up.
//   Piece channel: while o_empty is low, o_piece holds the oldest piece;
//   raise i_pop to take it. last_piece marks the final piece of a request.
//   A request yields zero to six pieces: none for an invalid clipper or a
//   fully covered clipper, the clipper itself when the boxes are disjoint.
//   Path: front register, then queue, then output register, where pieces show.
//   Throughput: one piece per cycle while the receiver pops, set by the back
//   end walking the piece mask; a request holds the back end until all of its
//   pieces are issued, up to six pieces per request.
//   Reset (i_rst_n low, synchronous) empties the front register, the queue
//   and the output register. When the receiver stalls, the output register
//   holds, then the queue fills, then o_full rises.
module box_subtract_3d #(
    parameter int QUEUE_DEPTH = bsub_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  bsub_pkg::t_req   i_req,
    output logic             o_empty,
    input  logic             i_pop,
    output bsub_pkg::t_piece o_piece
);
    import bsub_pkg::*;

    t_job    job_in;
    t_job    job_head;
    logic    q_push;
    logic    q_pop;
    t_q_stat q_stat;

    bsub_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_req    (i_req),
        .i_q_stat (q_stat),
        .o_q_push (q_push),
        .o_job    (job_in)
    );

    bsub_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_head  (job_head),
        .o_stat  (q_stat)
    );

    bsub_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (job_head),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_piece  (o_piece)
    );

endmodule

/* rtl/bsub_front.sv */
// Front end: registers one request, forms the intersection and the piece mask.
// Depends on bsub_pkg; feeds bsub_queue.
module bsub_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  bsub_pkg::t_req    i_req,
    input  bsub_pkg::t_q_stat i_q_stat,
    output logic              o_q_push,
    output bsub_pkg::t_job    o_job
);
    import bsub_pkg::*;

    t_req  r_req;
    logic  r_vld;
    t_box  clip;
    t_box  subj;
    t_box  isect;
    t_mask mask;
    logic  drop;
    logic  advance;

    always_comb begin
        clip  = '{r_req.clipper_min_x, r_req.clipper_min_y, r_req.clipper_min_z,
                  r_req.clipper_max_x, r_req.clipper_max_y, r_req.clipper_max_z};
        subj  = '{r_req.subject_min_x, r_req.subject_min_y, r_req.subject_min_z,
                  r_req.subject_max_x, r_req.subject_max_y, r_req.subject_max_z};
        isect.lo_x = (clip.lo_x > subj.lo_x) ? clip.lo_x : subj.lo_x;
        isect.lo_y = (clip.lo_y > subj.lo_y) ? clip.lo_y : subj.lo_y;
        isect.lo_z = (clip.lo_z > subj.lo_z) ? clip.lo_z : subj.lo_z;
        isect.hi_x = (clip.hi_x < subj.hi_x) ? clip.hi_x : subj.hi_x;
        isect.hi_y = (clip.hi_y < subj.hi_y) ? clip.hi_y : subj.hi_y;
        isect.hi_z = (clip.hi_z < subj.hi_z) ? clip.hi_z : subj.hi_z;

        mask = '0;
        if (box_ok(clip)) begin
            if (!box_ok(isect)) begin
                mask[KIND_CLIP] = 1'b1;
            end else begin
                for (int k = 0; k < NUM_KINDS - 1; k++) begin
                    mask[k] = box_ok(build_piece(clip, isect, KIND_W'(k)));
                end
            end
        end
    end

    // Requests that yield no piece are dropped here and never reach the queue.
    assign drop     = (mask == '0);
    assign advance  = r_vld && (drop || !i_q_stat.full);
    assign o_full   = r_vld && !advance;
    assign o_q_push = r_vld && !drop && !i_q_stat.full;
    assign o_job    = '{clip, isect, mask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push && !o_full) begin
            r_vld <= 1'b1;
        end else if (advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_req <= i_req;
        end
    end

endmodule

/* rtl/bsub_queue.sv */
// Short queue of classified requests between front and back end.
// Depends on bsub_pkg.
module bsub_queue #(
    parameter int DEPTH = bsub_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bsub_pkg::t_job     i_job,
    input  logic               i_pop,
    output bsub_pkg::t_job     o_head,
    output bsub_pkg::t_q_stat  o_stat
);
    import bsub_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    assign n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue underflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/bsub_back.sv */
// Back end: walks the head request's piece mask, one piece per cycle when the
// output register is empty or popped. Depends on bsub_pkg; reads bsub_queue.
module bsub_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsub_pkg::t_job    i_head,
    input  bsub_pkg::t_q_stat i_q_stat,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output bsub_pkg::t_piece  o_piece
);
    import bsub_pkg::*;

    t_mask  r_done;
    t_mask  n_done;
    logic   r_out_vld;
    t_piece r_out;
    t_mask  rem;
    t_mask  pick;
    t_kind  kind;
    logic   pick_last;
    logic   load;
    t_box   box;

    assign rem = i_head.mask & ~r_done;

    // Lowest pending kind goes first.
    always_comb begin
        pick = '0;
        kind = KIND_CLIP;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if (rem[k]) begin
                pick = t_mask'(1) << k;
                kind = KIND_W'(k);
            end
        end
    end

    assign pick_last = ((rem & ~pick) == '0);
    assign load      = !i_q_stat.empty && (!r_out_vld || i_pop);
    assign o_q_pop   = load && pick_last;
    assign box       = build_piece(i_head.clip, i_head.isect, kind);
    assign n_done    = pick_last ? '0 : (r_done | pick);

    assign o_empty = !r_out_vld;
    assign o_piece = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_done    <= n_done;
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= '{box.lo_x, box.lo_y, box.lo_z, box.hi_x, box.hi_y, box.hi_z,
                       pick_last};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (rem != '0))
        else $error("piece issued with nothing pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> $onehot(pick))
        else $error("piece select not one-hot");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_done == '0) && r_out.last_piece)
        else $error("request retired without last piece");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.empty |-> (r_done == '0))
        else $error("progress left over with empty queue");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for box_subtract_3d: directed and random box pairs against a local piece predictor.
// Depends on bsub_pkg and box_subtract_3d; stalls both queue sides, including a long pop hold-off.
module tb;
    import bsub_pkg::*;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   push;
    logic   full;
    t_req   req;
    logic   empty;
    logic   pop;
    t_piece piece;

    t_piece expected_pieces[$];
    int     fail_count = 0;
    int     push_idle_pct = 0;
    int     pop_idle_pct = 0;
    int     pop_hold = 0;

    box_subtract_3d u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_req   (req),
        .o_empty (empty),
        .i_pop   (pop),
        .o_piece (piece)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pieces of the clipper left after the subject is cut out, in emit order.
    function automatic void predict_pieces(input t_req r);
        t_coord c_lo[3], c_hi[3], s_lo[3], s_hi[3], x_lo[3], x_hi[3];
        t_coord p_lo[6][3], p_hi[6][3];
        t_piece found[$];
        t_piece pc;
        bit     c_ok, x_ok, p_ok;
        c_lo[0] = r.clipper_min_x; c_lo[1] = r.clipper_min_y; c_lo[2] = r.clipper_min_z;
        c_hi[0] = r.clipper_max_x; c_hi[1] = r.clipper_max_y; c_hi[2] = r.clipper_max_z;
        s_lo[0] = r.subject_min_x; s_lo[1] = r.subject_min_y; s_lo[2] = r.subject_min_z;
        s_hi[0] = r.subject_max_x; s_hi[1] = r.subject_max_y; s_hi[2] = r.subject_max_z;
        c_ok = 1'b1;
        x_ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            x_lo[a] = (c_lo[a] > s_lo[a]) ? c_lo[a] : s_lo[a];
            x_hi[a] = (c_hi[a] < s_hi[a]) ? c_hi[a] : s_hi[a];
            if (!(c_lo[a] < c_hi[a])) c_ok = 1'b0;
            if (!(x_lo[a] < x_hi[a])) x_ok = 1'b0;
        end
        if (!c_ok) return;
        if (!x_ok) begin
            pc = '{c_lo[0], c_lo[1], c_lo[2], c_hi[0], c_hi[1], c_hi[2], 1'b1};
            expected_pieces = {expected_pieces, pc};
            return;
        end
        for (int k = 0; k < 6; k++) begin
            for (int a = 0; a < 3; a++) begin
                p_lo[k][a] = c_lo[a];
                p_hi[k][a] = c_hi[a];
            end
        end
        p_lo[KIND_FRONT][0]  = x_hi[0]; p_lo[KIND_FRONT][1]  = x_lo[1];
        p_lo[KIND_FRONT][2]  = x_lo[2];
        p_hi[KIND_BEHIND][0] = x_lo[0]; p_hi[KIND_BEHIND][1] = x_hi[1];
        p_hi[KIND_BEHIND][2] = x_hi[2];
        p_lo[KIND_RIGHT][0]  = x_lo[0]; p_lo[KIND_RIGHT][1]  = x_lo[1];
        p_lo[KIND_RIGHT][2]  = x_hi[2];
        p_hi[KIND_LEFT][0]   = x_hi[0]; p_hi[KIND_LEFT][1]   = x_lo[1];
        p_hi[KIND_LEFT][2]   = x_hi[2];
        p_lo[KIND_TOP][0]    = x_lo[0]; p_lo[KIND_TOP][1]    = x_hi[1];
        p_lo[KIND_TOP][2]    = x_lo[2];
        p_hi[KIND_BOTTOM][0] = x_hi[0]; p_hi[KIND_BOTTOM][1] = x_hi[1];
        p_hi[KIND_BOTTOM][2] = x_lo[2];
        for (int k = 0; k < 6; k++) begin
            p_ok = 1'b1;
            for (int a = 0; a < 3; a++) begin
                if (!(p_lo[k][a] < p_hi[k][a])) p_ok = 1'b0;
            end
            if (p_ok) begin
                pc = '{p_lo[k][0], p_lo[k][1], p_lo[k][2],
                       p_hi[k][0], p_hi[k][1], p_hi[k][2], 1'b0};
                found = {found, pc};
            end
        end
        if (found.size() > 0) found[found.size()-1].last_piece = 1'b1;
        expected_pieces = {expected_pieces, found};
    endfunction

    function automatic t_req make_req(input int cx0, cy0, cz0, cx1, cy1, cz1,
                                      input int sx0, sy0, sz0, sx1, sy1, sz1);
        t_req r;
        r.clipper_min_x = t_coord'(cx0); r.clipper_min_y = t_coord'(cy0);
        r.clipper_min_z = t_coord'(cz0); r.clipper_max_x = t_coord'(cx1);
        r.clipper_max_y = t_coord'(cy1); r.clipper_max_z = t_coord'(cz1);
        r.subject_min_x = t_coord'(sx0); r.subject_min_y = t_coord'(sy0);
        r.subject_min_z = t_coord'(sz0); r.subject_max_x = t_coord'(sx1);
        r.subject_max_y = t_coord'(sy1); r.subject_max_z = t_coord'(sz1);
        return r;
    endfunction

    // Mostly overlapping boxes near a random base; the rest invalid, disjoint,
    // covered or plain noise.
    function automatic t_req random_req();
        int c_lo[3], c_hi[3], s_lo[3], s_hi[3];
        int base, mode, ax, tmp;
        t_req r;
        mode = $urandom_range(99);
        if (mode < 10) begin
            r = t_req'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return r;
        end
        for (int a = 0; a < 3; a++) begin
            base    = int'($urandom_range(65300)) - 32700;
            c_lo[a] = base + int'($urandom_range(30));
            c_hi[a] = c_lo[a] + 1 + int'($urandom_range(30));
            s_lo[a] = base - 20 + int'($urandom_range(60));
            s_hi[a] = s_lo[a] + 1 + int'($urandom_range(40));
            if (mode >= 24 && mode < 30) begin
                s_lo[a] = c_lo[a] - int'($urandom_range(10));
                s_hi[a] = c_hi[a] + int'($urandom_range(10));
            end
        end
        ax = $urandom_range(2);
        if (mode < 18) begin
            // swap or collapse one clipper axis
            tmp = c_lo[ax];
            c_lo[ax] = c_hi[ax];
            c_hi[ax] = ($urandom_range(1) != 0) ? tmp : c_lo[ax];
        end else if (mode < 24) begin
            s_hi[ax] = c_lo[ax] - int'($urandom_range(5));
            s_lo[ax] = s_hi[ax] - 1 - int'($urandom_range(10));
        end
        return make_req(c_lo[0], c_lo[1], c_lo[2], c_hi[0], c_hi[1], c_hi[2],
                        s_lo[0], s_lo[1], s_lo[2], s_hi[0], s_hi[1], s_hi[2]);
    endfunction

    task automatic push_request(input t_req r);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req  <= r;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_pieces(r);
    endtask

    function automatic void match_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic void check_piece(input t_piece got);
        t_piece want;
        if (expected_pieces.size() == 0) begin
            $error("unexpected piece %p", got);
            fail_count++;
            return;
        end
        want = expected_pieces.pop_front();
        match_field("piece_min_x", want.piece_min_x, got.piece_min_x);
        match_field("piece_min_y", want.piece_min_y, got.piece_min_y);
        match_field("piece_min_z", want.piece_min_z, got.piece_min_z);
        match_field("piece_max_x", want.piece_max_x, got.piece_max_x);
        match_field("piece_max_y", want.piece_max_y, got.piece_max_y);
        match_field("piece_max_z", want.piece_max_z, got.piece_max_z);
        match_field("last_piece", want.last_piece, got.last_piece);
    endfunction

    // Piece side: check each popped piece, then pick pop for the next cycle.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (pop && !empty) check_piece(piece);
                if (pop_hold > 0) begin
                    pop_hold--;
                    pop <= 1'b0;
                end else begin
                    pop <= ($urandom_range(99) >= pop_idle_pct);
                end
            end
        end
    end

    task automatic test_invalid_clipper();
        push_request(make_req(0, 0, 0, 0, 10, 10, 2, 2, 2, 5, 5, 5));
        push_request(make_req(0, 9, 0, 10, 3, 10, 2, 2, 2, 5, 5, 5));
        push_request(make_req(0, 0, 7, 10, 10, 7, 2, 2, 2, 5, 5, 5));
        push_request(make_req(32767, -32768, 0, -32768, 32767, 1, 0, 0, 0, 1, 1, 1));
    endtask

    task automatic test_disjoint();
        push_request(make_req(0, 0, 0, 10, 10, 10, 20, 0, 0, 30, 10, 10));
        // touching faces do not overlap
        push_request(make_req(0, 0, 0, 10, 10, 10, 0, 10, 0, 10, 20, 10));
        push_request(make_req(0, 0, 0, 10, 10, 10, 0, 0, -10, 10, 10, 0));
        // invalid subject leaves the clipper whole
        push_request(make_req(0, 0, 0, 10, 10, 10, 8, 2, 2, 3, 5, 5));
    endtask

    task automatic test_covered();
        push_request(make_req(0, 0, 0, 10, 10, 10, 0, 0, 0, 10, 10, 10));
        push_request(make_req(0, 0, 0, 10, 10, 10, -5, -5, -5, 15, 15, 15));
    endtask

    task automatic test_single_faces();
        push_request(make_req(0, 0, 0, 10, 10, 10, -5, -5, -5, 6, 15, 15));
        push_request(make_req(0, 0, 0, 10, 10, 10, 4, -5, -5, 15, 15, 15));
        push_request(make_req(0, 0, 0, 10, 10, 10, -5, -5, -5, 15, 15, 6));
        push_request(make_req(0, 0, 0, 10, 10, 10, -5, 4, -5, 15, 15, 15));
        push_request(make_req(0, 0, 0, 10, 10, 10, -5, -5, -5, 15, 6, 15));
        push_request(make_req(0, 0, 0, 10, 10, 10, -5, -5, 4, 15, 15, 15));
        push_request(make_req(0, 0, 0, 10, 10, 10, 3, 3, 3, 7, 7, 7));
    endtask

    task automatic test_extremes();
        push_request(make_req(-32768, -32768, -32768, 32767, 32767, 32767,
                              -1, -1, -1, 1, 1, 1));
        push_request(make_req(-32768, -32768, -32768, 32767, 32767, 32767,
                              -32768, -32768, -32768, 32767, 32767, 32767));
        push_request(make_req(-32768, -32768, -32768, 32767, 32767, 32767,
                              32766, -32768, 0, 32767, 32767, 32767));
        push_request(make_req(32766, 32766, 32766, 32767, 32767, 32767,
                              -32768, -32768, -32768, -32767, -32767, -32767));
    endtask

    // Hold pop off long enough for the block to fill and raise full.
    task automatic test_backpressure();
        t_req r;
        pop_hold = 80;
        for (int i = 0; i < 12; i++) begin
            r = random_req();
            push_request(r);
        end
    endtask

    task automatic test_random(input int count, input int push_pct, input int pop_pct);
        push_idle_pct = push_pct;
        pop_idle_pct  = pop_pct;
        for (int i = 0; i < count; i++) push_request(random_req());
    endtask

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        push  = 1'b0;
        pop   = 1'b0;
        req   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        push_idle_pct = 29;
        pop_idle_pct  = 77;
        test_invalid_clipper();
        test_disjoint();
        test_covered();
        test_single_faces();
        test_extremes();
        test_backpressure();
        test_random(105, 29, 77);
        test_random(105, 77, 29);
        test_random(105, 0, 0);
        push <= 1'b0;
        while (expected_pieces.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/bsub_pkg.sv
rtl/bsub_front.sv
rtl/bsub_queue.sv
rtl/bsub_back.sv
rtl/box_subtract_3d.sv
dv/tb.sv
